// ----- rtl/deq_pkg.sv -----
package deq_pkg;

  // Default ring capacity
  localparam int unsigned DEQ_DEPTH = 16;

  // Field widths
  localparam int unsigned OP_W          = 3;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned ENTRY_COUNT_W = 5;

  // Operation codes; any other code behaves as peek
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK       = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [WORD_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  popped_value;
    logic                      popped_valid;
    logic signed [WORD_W-1:0]  front_value;
    logic signed [WORD_W-1:0]  back_value;
    logic                      not_empty;
    logic                      push_dropped;
    logic [ENTRY_COUNT_W-1:0]  entry_count;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;
    logic rd_en;
    logic load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

// ----- rtl/deq_ctrl.sv -----
module deq_ctrl
  import deq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance through update, memory read and result load
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Drive datapath commands and the request stall
  always_comb begin
    req_stall = 1'b1;
    cmd       = '0;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        cmd.take  = req_valid;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      ST_FINISH: begin
        cmd.load = !sts.out_busy;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

endmodule

// ----- rtl/deq_datapath.sv -----
module deq_datapath
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = DEQ_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data,
  input  cmd_t cmd,
  output sts_t sts
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [AW-1:0] LAST_IX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

  logic signed [WORD_W-1:0] mem [DEPTH];

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;

  logic signed [WORD_W-1:0] front_q;
  logic signed [WORD_W-1:0] back_q;
  logic signed [WORD_W-1:0] rd_front;
  logic signed [WORD_W-1:0] rd_back;
  logic signed [WORD_W-1:0] popped;
  logic signed [WORD_W-1:0] popped_next;
  logic                     popped_ok;
  logic                     popped_ok_next;
  logic                     dropped;
  logic                     dropped_next;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [SW-1:0]            tail_sum;
  logic [SW-1:0]            last_sum;
  logic [AW-1:0]            tail_ix;
  logic [AW-1:0]            last_ix;
  logic [AW-1:0]            head_dec;
  logic [AW-1:0]            head_inc;
  logic [OP_W-1:0]          op;

  // Fold a sum below twice the depth back into the ring
  function automatic logic [AW-1:0] ring_wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
    return r[AW-1:0];
  endfunction

  // Ring positions around the head
  always_comb begin
    tail_sum = SW'(head) + SW'(cnt);
    last_sum = (cnt == '0) ? SW'(head) : (tail_sum - SW'(1));
    tail_ix  = ring_wrap(tail_sum);
    last_ix  = ring_wrap(last_sum);
    head_dec = (head == '0) ? LAST_IX : (head - AW'(1));
    head_inc = (head == LAST_IX) ? '0 : (head + AW'(1));
  end

  // Work out the pointer update, the store write and the popped word
  always_comb begin
    op             = req_data.operation;
    head_next      = head;
    cnt_next       = cnt;
    wr_en          = 1'b0;
    wr_addr        = tail_ix;
    popped_next    = '0;
    popped_ok_next = 1'b0;
    dropped_next   = 1'b0;
    if (op inside {OP_PUSH_FRONT, OP_PUSH_BACK}) begin
      if (cnt >= FULL_C) begin
        dropped_next = 1'b1;
      end else begin
        wr_en    = 1'b1;
        cnt_next = cnt + CW'(1);
        if (op == OP_PUSH_FRONT) begin
          head_next = head_dec;
          wr_addr   = head_dec;
        end
      end
    end else if (op inside {OP_POP_FRONT, OP_POP_BACK}) begin
      if (cnt != '0) begin
        popped_ok_next = 1'b1;
        cnt_next       = cnt - CW'(1);
        if (op == OP_POP_FRONT) begin
          popped_next = front_q;
          head_next   = head_inc;
        end else begin
          popped_next = back_q;
        end
      end
    end
  end

  // Update head and count on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      cnt  <= '0;
    end else if (cmd.take) begin
      head <= head_next;
      cnt  <= cnt_next;
    end
  end

  // Capture the per-beat flags
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      popped    <= popped_next;
      popped_ok <= popped_ok_next;
      dropped   <= dropped_next;
    end
  end

  // Write pushed words into the ring
  always_ff @(posedge clk) begin
    if (cmd.take && wr_en) begin
      mem[wr_addr] <= req_data.item_value;
    end
  end

  // Read the new front and back words
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_front <= mem[head];
      rd_back  <= mem[last_ix];
    end
  end

  // Keep the current ends for the next pop
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      front_q <= rd_front;
      back_q  <= rd_back;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp_data.popped_value <= popped;
      rsp_data.popped_valid <= popped_ok;
      rsp_data.front_value  <= (cnt != '0) ? rd_front : '0;
      rsp_data.back_value   <= (cnt != '0) ? rd_back : '0;
      rsp_data.not_empty    <= (cnt != '0);
      rsp_data.push_dropped <= dropped;
      rsp_data.entry_count  <= ENTRY_COUNT_W'(cnt);
    end
  end

  assign sts.out_busy = rsp_valid && rsp_stall;

endmodule

// ----- rtl/double_ended_queue_unit.sv -----
// The sequence for each request is pointer update and store write, then the
// two-port read of the front and back slots, then the result load, which waits
// while the previous result is still stalled. A new request is taken only once
// the result of the last one has been loaded.
// Reset (rst, synchronous, active high) empties the queue; the slot store is
// not cleared, since words read from empty slots never reach the result.
module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = DEQ_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  cmd_t cmd;
  sts_t sts;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- rtl/deq_checker.sv -----
module deq_checker
  import deq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req_data,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp_data
);

  // A stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result beat changed");

  // One item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while an item is in work");

  // An empty queue shows zero ends and zero count
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.not_empty |->
      rsp_data.front_value == '0 && rsp_data.back_value == '0 &&
      rsp_data.entry_count == '0)
    else $error("empty result with nonzero fields");

  // A beat cannot both pop a word and drop a push
  a_pop_or_drop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_data.popped_valid && rsp_data.push_dropped))
    else $error("pop and dropped push in one beat");

  // No popped word means a zero popped value
  a_pop_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.popped_valid |-> rsp_data.popped_value == '0)
    else $error("popped value without a pop");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (.*);

// ----- sim/deque_result_checker.sv -----
module deque_result_checker
  import deq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req_data,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp_data,
  output int   mismatch_count,
  output int   results_owed
);

  localparam int unsigned HEAD_W     = $clog2(DEQ_DEPTH);
  localparam int unsigned OWED_DEPTH = 16;

  // Shadow ring: slot array, index of the front word, number of words held
  logic signed [WORD_W-1:0] slots [DEQ_DEPTH];
  logic [HEAD_W-1:0]        front_slot;
  logic [HEAD_W:0]          held_words;

  // Owed results in arrival order: read at owed_head, written at owed_tail
  rsp_t owed_results [OWED_DEPTH];
  int   owed_head;
  int   owed_tail;
  int   errors;

  function automatic logic [HEAD_W-1:0] ring_step(logic [HEAD_W-1:0] pos, int unsigned offset);
    return HEAD_W'((int'(pos) + offset) % DEQ_DEPTH);
  endfunction

  // Apply one operation to the shadow ring and return the result it produces
  function automatic rsp_t apply_deque_op(req_t beat);
    rsp_t result;
    logic [HEAD_W-1:0] last_slot;
    result = '0;
    case (beat.operation)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (held_words >= DEQ_DEPTH) begin
          result.push_dropped = 1'b1;
        end else if (beat.operation == OP_PUSH_FRONT) begin
          front_slot = ring_step(front_slot, DEQ_DEPTH - 1);
          slots[front_slot] = beat.item_value;
          held_words++;
        end else begin
          slots[ring_step(front_slot, 32'(held_words))] = beat.item_value;
          held_words++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        // pop on an empty ring leaves everything as is
        if (held_words != 0) begin
          if (beat.operation == OP_POP_FRONT) begin
            result.popped_value = slots[front_slot];
            front_slot = ring_step(front_slot, 1);
          end else begin
            result.popped_value = slots[ring_step(front_slot, 32'(held_words) - 1)];
          end
          held_words--;
          result.popped_valid = 1'b1;
        end
      end
      default: begin
        // peek, and the unused codes that behave as peek
      end
    endcase
    if (held_words != 0) begin
      last_slot = ring_step(front_slot, 32'(held_words) - 1);
      result.front_value = slots[front_slot];
      result.back_value  = slots[last_slot];
      result.not_empty   = 1'b1;
    end
    result.entry_count = held_words;
    return result;
  endfunction

  task automatic check_field(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      errors++;
    end
  endtask

  // Compare each result beat with the oldest owed result, then log new request beats
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      front_slot = '0;
      held_words = '0;
      owed_head  = 0;
      owed_tail  = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (owed_tail == owed_head) begin
          $display("%0t: result beat with nothing owed, expected none actual %h",
                   $time, rsp_data);
          errors++;
        end else begin
          want = owed_results[owed_head % OWED_DEPTH];
          owed_head++;
          check_field("popped_value", want.popped_value, rsp_data.popped_value);
          check_field("popped_valid", want.popped_valid, rsp_data.popped_valid);
          check_field("front_value", want.front_value, rsp_data.front_value);
          check_field("back_value", want.back_value, rsp_data.back_value);
          check_field("not_empty", want.not_empty, rsp_data.not_empty);
          check_field("push_dropped", want.push_dropped, rsp_data.push_dropped);
          check_field("entry_count", want.entry_count, rsp_data.entry_count);
        end
      end
      if (req_valid && !req_stall) begin
        owed_results[owed_tail % OWED_DEPTH] = apply_deque_op(req_data);
        owed_tail++;
      end
    end
    results_owed   <= owed_tail - owed_head;
    mismatch_count <= errors;
  end

endmodule

// ----- sim/tb.sv -----
module tb;
  import deq_pkg::*;

  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned PHASES       = 11;
  localparam int unsigned PHASE_ITEMS  = 50;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_stall = 1'b0;
  req_t req_data  = '0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp_data;

  int mismatch_count;
  int results_owed;

  // Push share in percent for each random phase
  int unsigned push_pct [PHASES] = '{90, 25, 75, 50, 75, 25, 90, 50, 25, 90, 50};

  // Idling controls for the sender (send_calm) and the receiver (recv_calm, long_hold_pending)
  bit send_calm;
  bit recv_calm;
  bit long_hold_pending;

  double_ended_queue_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  deque_result_checker result_check (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req_data       (req_data),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp_data       (rsp_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always #5 clk = ~clk;

  // Offer one request beat after a random gap (none when calm) and hold it until accepted
  task automatic offer(logic [OP_W-1:0] op, logic signed [WORD_W-1:0] value);
    req_t beat;
    int unsigned gap;
    beat.operation  = op;
    beat.item_value = value;
    gap = send_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= beat;
    do @(posedge clk); while (req_stall);
  endtask

  // Stop offering until every owed result has come back
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  function automatic logic signed [WORD_W-1:0] draw_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] draw_op(int unsigned push_share);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < push_share) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (roll < 94) return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    if (roll < 97) return OP_PEEK;
    // unused codes above peek
    return OP_W'(OP_PEEK + $urandom_range(1, 3));
  endfunction

  // Result receiver: random stall per beat unless calm, one long hold-off on request
  initial begin : rsp_sink
    int unsigned hold;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        hold = LONG_HOLD;
      end else begin
        hold = recv_calm ? 0 : $urandom_range(0, 15);
      end
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        rsp_stall <= 1'b0;
      end
      do @(posedge clk); while (!rsp_valid);
    end
  end

  // Stimulus: directed corner cases, then biased random phases
  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty ring: peek and both pops
    offer(OP_PEEK, 32'sh0);
    offer(OP_POP_FRONT, 32'sh1234_5678);
    offer(OP_POP_BACK, -1);
    // extreme words at both ends, then remove them again
    offer(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
    offer(OP_PUSH_BACK, 32'sh8000_0000);
    offer(OP_W'(OP_PEEK + 1), -1);
    offer(OP_POP_FRONT, 32'sh0);
    offer(OP_POP_BACK, 32'sh0);
    offer(OP_W'(OP_PEEK + 2), 32'sh5A5A_A5A5);
    offer(OP_W'(OP_PEEK + 3), 32'sh0);
    // fill to capacity from both ends, then push into a full ring
    for (int i = 0; i < DEQ_DEPTH; i++) begin
      offer(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, draw_word());
    end
    offer(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
    offer(OP_PUSH_BACK, 32'sh8000_0000);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      // back-to-back requests against a receiver that holds off for a long stretch
      if (phase == 4) begin
        send_calm = 1'b1;
        long_hold_pending = 1'b1;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        offer(draw_op(push_pct[phase]), draw_word());
      end
      if (phase % 3 == 2) drain();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
